### hdl/hsrs_pkg.sv
// Package for the hourly sample rank scan block.
// Holds shared constants, the verdict encoding and the result struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hsrs_pkg;

  localparam int HOURS_DEF          = 24;
  localparam int QUARTILE_COUNT_DEF = 18;

  localparam int SAMPLE_W = 8;
  localparam int BELOW_W  = 5;

  localparam logic [SAMPLE_W-1:0] UNSET     = 8'hFF;
  localparam logic [BELOW_W-1:0]  BELOW_CAP = 5'd31;

  localparam logic CFG_BELOW_LIMIT = 1'b0;
  localparam logic CFG_TEST_VALUE  = 1'b1;

  typedef enum logic [2:0] {
    VERDICT_UNDECIDED = 3'b001,
    VERDICT_TRUE      = 3'b010,
    VERDICT_FALSE     = 3'b100
  } verdict_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] min_value;
    logic [SAMPLE_W-1:0] max_value;
    logic [BELOW_W-1:0]  count_below;
    logic                in_top;
    logic                in_bottom;
  } result_t;

endpackage

`default_nettype wire

### hdl/hsrs_scan.sv
// Scan state and per-sample update for the hourly sample rank scan.
// Keeps running min, max, tallies and quartile verdicts; depends on hsrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsrs_scan
  import hsrs_pkg::*;
#(
  parameter int HOURS          = HOURS_DEF,
  parameter int QUARTILE_COUNT = QUARTILE_COUNT_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step,
  input  wire logic [SAMPLE_W-1:0] sample,
  input  wire logic                last,
  input  wire logic [SAMPLE_W-1:0] below_limit,
  input  wire logic [SAMPLE_W-1:0] test_value,
  output logic                     done,
  output result_t                  result
);

  localparam int CW = $clog2(HOURS);
  localparam int TW = $clog2(QUARTILE_COUNT + 1);

  logic [SAMPLE_W-1:0] min_r, min_nxt;
  logic [SAMPLE_W-1:0] max_r, max_nxt;
  logic [BELOW_W-1:0]  below_r, below_nxt;
  logic [TW-1:0]       lower_r, lower_nxt;
  logic [TW-1:0]       higher_r, higher_nxt;
  verdict_t            top_r, top_nxt;
  verdict_t            bot_r, bot_nxt;
  logic [CW-1:0]       cnt_r;
  logic                unset;

  assign unset = (sample == UNSET);
  assign done  = last || (cnt_r == CW'(HOURS - 1));

  always_comb begin
    min_nxt    = (sample < min_r) ? sample : min_r;
    max_nxt    = max_r;
    below_nxt  = below_r;
    lower_nxt  = lower_r;
    higher_nxt = higher_r;
    top_nxt    = top_r;
    bot_nxt    = bot_r;
    if (!unset && ((max_r == UNSET) || (sample > max_r))) begin
      max_nxt = sample;
    end
    if ((sample < below_limit) && (below_r != BELOW_CAP)) begin
      below_nxt = below_r + BELOW_W'(1);
    end
    if (top_r == VERDICT_UNDECIDED) begin
      if ((test_value == UNSET) || unset) begin
        top_nxt = VERDICT_FALSE;
      end else if (sample < test_value) begin
        lower_nxt = lower_r + TW'(1);
        if (lower_nxt >= TW'(QUARTILE_COUNT)) begin
          top_nxt = VERDICT_TRUE;
        end
      end
    end
    if (bot_r == VERDICT_UNDECIDED) begin
      if (unset) begin
        bot_nxt = VERDICT_FALSE;
      end else if (sample > test_value) begin
        higher_nxt = higher_r + TW'(1);
        if (higher_nxt >= TW'(QUARTILE_COUNT)) begin
          bot_nxt = VERDICT_TRUE;
        end
      end
    end
  end

  always_comb begin
    result.min_value   = min_nxt;
    result.max_value   = max_nxt;
    result.count_below = below_nxt;
    result.in_top      = (top_nxt == VERDICT_TRUE);
    result.in_bottom   = (bot_nxt == VERDICT_TRUE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && done)) begin
      min_r    <= UNSET;
      max_r    <= UNSET;
      below_r  <= '0;
      lower_r  <= '0;
      higher_r <= '0;
      top_r    <= VERDICT_UNDECIDED;
      bot_r    <= VERDICT_UNDECIDED;
      cnt_r    <= '0;
    end else if (step) begin
      min_r    <= min_nxt;
      max_r    <= max_nxt;
      below_r  <= below_nxt;
      lower_r  <= lower_nxt;
      higher_r <= higher_nxt;
      top_r    <= top_nxt;
      bot_r    <= bot_nxt;
      cnt_r    <= cnt_r + CW'(1);
    end
  end

endmodule

`default_nettype wire

### hdl/hourly_sample_rank_scan.sv
// The result of a scan is registered in out_r as its ending beat leaves staging.
// Throughput: one sample beat per cycle; a held result stalls only a scan-ending beat.
// The rate is set by the scan registers, which update on every advancing beat.
// Synchronous active-low reset clears the scan, the pipeline valids and the config
// registers (below_limit 0, test_value 255). Depends on hsrs_pkg and hsrs_scan.
`timescale 1ns / 1ps
`default_nettype none

module hourly_sample_rank_scan
  import hsrs_pkg::*;
#(
  parameter int HOURS          = HOURS_DEF,
  parameter int QUARTILE_COUNT = QUARTILE_COUNT_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [SAMPLE_W-1:0] cfg_wdata,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [SAMPLE_W-1:0] in_sample,
  input  wire logic                in_last,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [SAMPLE_W-1:0]      out_min_value,
  output logic [SAMPLE_W-1:0]      out_max_value,
  output logic [BELOW_W-1:0]       out_count_below,
  output logic                     out_in_top,
  output logic                     out_in_bottom
);

  logic [SAMPLE_W-1:0] below_limit_r;
  logic [SAMPLE_W-1:0] test_value_r;
  logic                stg_valid_r;
  logic [SAMPLE_W-1:0] stg_sample_r;
  logic                stg_last_r;
  logic                out_valid_r;
  result_t             out_r;
  result_t             scan_res;
  logic                scan_done;
  logic                adv;

  assign adv      = stg_valid_r && (!scan_done || !out_valid_r || out_ready);
  assign in_ready = !stg_valid_r || adv;

  hsrs_scan #(
    .HOURS          (HOURS),
    .QUARTILE_COUNT (QUARTILE_COUNT)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (adv),
    .sample      (stg_sample_r),
    .last        (stg_last_r),
    .below_limit (below_limit_r),
    .test_value  (test_value_r),
    .done        (scan_done),
    .result      (scan_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      below_limit_r <= '0;
      test_value_r  <= UNSET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BELOW_LIMIT: below_limit_r <= cfg_wdata;
        CFG_TEST_VALUE:  test_value_r  <= cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ready) begin
      stg_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stg_sample_r <= in_sample;
      stg_last_r   <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && scan_done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && scan_done) begin
      out_r <= scan_res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_min_value   = out_r.min_value;
  assign out_max_value   = out_r.max_value;
  assign out_count_below = out_r.count_below;
  assign out_in_top      = out_r.in_top;
  assign out_in_bottom   = out_r.in_bottom;

endmodule

`default_nettype wire

### tb/hourly_sample_rank_scan_tb.sv
// Testbench for hourly_sample_rank_scan: it drives sample beats and checks every result
// against its own scan predictor. Depends on hsrs_pkg and the hourly_sample_rank_scan RTL.
`timescale 1ns / 1ps

module hourly_sample_rank_scan_tb;
  import hsrs_pkg::*;

  localparam int             CYCLE_LIMIT = 200000;
  localparam int             SETTLE      = 4;
  localparam logic [6:0]     RANK_MAX    = 7'd127;

  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } beat_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic                cfg_index;
  logic [SAMPLE_W-1:0] cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  logic [SAMPLE_W-1:0] in_sample;
  logic                in_last;
  logic                out_valid;
  logic                out_ready;
  logic [SAMPLE_W-1:0] out_min_value;
  logic [SAMPLE_W-1:0] out_max_value;
  logic [BELOW_W-1:0]  out_count_below;
  logic                out_in_top;
  logic                out_in_bottom;

  beat_t   sample_fifo[$];
  result_t pending_results[$];
  beat_t   next_beat;
  bit      in_taken;
  bit      steady;
  int      errors;
  int      cycles;
  int      beats_sent;
  int      beats_taken;
  int      phase_left;

  // Predicted scan state and register copies.
  logic [SAMPLE_W-1:0] lim_reg;
  logic [SAMPLE_W-1:0] tv_reg;
  logic [SAMPLE_W-1:0] run_min;
  logic [SAMPLE_W-1:0] run_max;
  logic [BELOW_W-1:0]  below_cnt;
  logic [6:0]          higher_cnt;
  logic [6:0]          lower_cnt;
  verdict_t            top_v;
  verdict_t            bot_v;
  int                  hour_cnt;

  hourly_sample_rank_scan u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample      (in_sample),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_min_value  (out_min_value),
    .out_max_value  (out_max_value),
    .out_count_below(out_count_below),
    .out_in_top     (out_in_top),
    .out_in_bottom  (out_in_bottom)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic clear_scan();
    run_min    = UNSET;
    run_max    = UNSET;
    below_cnt  = '0;
    higher_cnt = '0;
    lower_cnt  = '0;
    top_v      = VERDICT_UNDECIDED;
    bot_v      = VERDICT_UNDECIDED;
    hour_cnt   = 0;
  endtask

  task automatic scan_fold(input logic [SAMPLE_W-1:0] s, input logic lst);
    result_t r;
    if (s < run_min) run_min = s;
    if (s != UNSET && (run_max == UNSET || s > run_max)) run_max = s;
    if (s < lim_reg && below_cnt != BELOW_CAP) below_cnt = below_cnt + 1'b1;
    if (top_v == VERDICT_UNDECIDED) begin
      if (tv_reg == UNSET || s == UNSET) begin
        top_v = VERDICT_FALSE;
      end else if (s < tv_reg) begin
        if (lower_cnt != RANK_MAX) lower_cnt = lower_cnt + 1'b1;
        if (lower_cnt >= 7'(QUARTILE_COUNT_DEF)) top_v = VERDICT_TRUE;
      end
    end
    if (bot_v == VERDICT_UNDECIDED) begin
      if (s == UNSET) begin
        bot_v = VERDICT_FALSE;
      end else if (s > tv_reg) begin
        if (higher_cnt != RANK_MAX) higher_cnt = higher_cnt + 1'b1;
        if (higher_cnt >= 7'(QUARTILE_COUNT_DEF)) bot_v = VERDICT_TRUE;
      end
    end
    hour_cnt++;
    if (lst || hour_cnt >= HOURS_DEF) begin
      r.min_value   = run_min;
      r.max_value   = run_max;
      r.count_below = below_cnt;
      r.in_top      = (top_v == VERDICT_TRUE);
      r.in_bottom   = (bot_v == VERDICT_TRUE);
      pending_results.push_back(r);
      clear_scan();
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    result_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else if (!rst_n) begin
      lim_reg  = '0;
      tv_reg   = UNSET;
      in_taken = 1'b0;
      clear_scan();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual min %0d max %0d below %0d",
                   $time, out_min_value, out_max_value, out_count_below);
        end else begin
          want = pending_results.pop_front();
          check_field("min_value", int'(want.min_value), int'(out_min_value));
          check_field("max_value", int'(want.max_value), int'(out_max_value));
          check_field("count_below", int'(want.count_below), int'(out_count_below));
          check_field("in_top", int'(want.in_top), int'(out_in_top));
          check_field("in_bottom", int'(want.in_bottom), int'(out_in_bottom));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_BELOW_LIMIT: lim_reg = cfg_wdata;
          CFG_TEST_VALUE:  tv_reg  = cfg_wdata;
          default: ;
        endcase
      end
      in_taken = in_valid && in_ready;
      if (in_taken) begin
        beats_taken++;
        scan_fold(in_sample, in_last);
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      out_ready <= steady || ($urandom_range(0, 99) >= 16);
      if (!in_valid || in_taken) begin
        if (sample_fifo.size() > 0 && (steady || $urandom_range(0, 99) >= 16)) begin
          next_beat = sample_fifo.pop_front();
          in_sample <= next_beat.sample;
          in_last   <= next_beat.last;
          in_valid  <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic push_beat(input logic [SAMPLE_W-1:0] s, input logic lst);
    beat_t b;
    if (phase_left > 0) begin
      b.sample = s;
      b.last   = lst;
      sample_fifo.push_back(b);
      beats_sent++;
      phase_left--;
    end
  endtask

  task automatic write_reg(input logic idx, input logic [SAMPLE_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
  endtask

  task automatic configure(input logic [SAMPLE_W-1:0] lim, input logic [SAMPLE_W-1:0] tv);
    write_reg(CFG_BELOW_LIMIT, lim);
    write_reg(CFG_TEST_VALUE, tv);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (beats_taken != beats_sent || pending_results.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Bias 1 leans below the test value, bias 2 above it, bias 0 is uniform.
  function automatic logic [SAMPLE_W-1:0] pick_sample(input int bias, input int unset_pct);
    if ($urandom_range(0, 99) < unset_pct) return UNSET;
    if (bias == 1 && tv_reg > 0 && $urandom_range(0, 99) < 85)
      return SAMPLE_W'($urandom_range(0, tv_reg - 1));
    if (bias == 2 && tv_reg < 8'd254 && $urandom_range(0, 99) < 85)
      return SAMPLE_W'($urandom_range(tv_reg + 1, 254));
    return SAMPLE_W'($urandom_range(0, 254));
  endfunction

  task automatic add_scan();
    int mode;
    int len;
    int bias;
    int pct;
    mode = $urandom_range(0, 99);
    bias = $urandom_range(0, 2);
    if (mode < 35) begin
      len = HOURS_DEF;
      pct = 2;
      for (int i = 1; i <= len; i++) push_beat(pick_sample(bias, pct), i == len);
    end else if (mode < 65) begin
      len = $urandom_range(1, HOURS_DEF);
      pct = 15;
      for (int i = 1; i <= len; i++) push_beat(pick_sample(bias, pct), i == len);
    end else if (mode < 85) begin
      // The scan is closed by its length alone.
      for (int i = 1; i <= HOURS_DEF; i++) push_beat(pick_sample(bias, 2), 1'b0);
    end else begin
      len = $urandom_range(1, 6);
      for (int i = 1; i <= len; i++)
        push_beat(pick_sample(bias, 30), $urandom_range(0, 3) == 0);
    end
  endtask

  initial begin
    logic [SAMPLE_W-1:0] lim_tab[8];
    logic [SAMPLE_W-1:0] tv_tab[8];
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_BELOW_LIMIT;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_sample = '0;
    in_last   = 1'b0;
    out_ready = 1'b0;
    steady    = 1'b0;
    lim_tab   = '{8'd128, 8'd0, 8'd255, 8'd1, 8'd254, 8'd0, 8'd0, 8'd0};
    tv_tab    = '{8'd128, 8'd255, 8'd0, 8'd254, 8'd1, 8'd0, 8'd0, 8'd0};
    for (int p = 5; p < 8; p++) begin
      lim_tab[p] = SAMPLE_W'($urandom_range(0, 255));
      tv_tab[p]  = SAMPLE_W'($urandom_range(0, 255));
    end
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Reset registers: unset and extreme samples, zero limit, unset test value.
    phase_left = 100;
    push_beat(UNSET, 1'b1);
    push_beat(8'd0, 1'b1);
    push_beat(8'd254, 1'b1);
    push_beat(8'd10, 1'b0);
    push_beat(8'd200, 1'b0);
    push_beat(UNSET, 1'b1);
    drain();

    // Bottom quartile reached, then an unset sample that must not undo it.
    configure(8'd255, 8'd0);
    phase_left = 100;
    for (int i = 0; i < QUARTILE_COUNT_DEF; i++)
      push_beat(SAMPLE_W'($urandom_range(1, 254)), 1'b0);
    push_beat(UNSET, 1'b1);
    drain();

    for (int p = 0; p < 8; p++) begin
      configure(lim_tab[p], tv_tab[p]);
      steady     = (p == 2);
      phase_left = 50;
      while (phase_left > 0) add_scan();
      drain();
    end
    steady = 1'b0;
    repeat (8) @(negedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
